// File: rtl/mbrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU request and reply check package
// Word types, opcodes and the CRC-16/Modbus byte update shared by the block.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  // Input word opcodes.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RX_BYTE = 1'b1;

  // Output word kinds.
  localparam logic KIND_TX_BYTE = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // CRC-16/Modbus: reflected polynomial, all-ones start value.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // A request frame is eight bytes; a usable reply is at least five.
  localparam int unsigned FRAME_LEN = 8;
  localparam logic [7:0]  MIN_REPLY = 8'd5;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  device_addr;
    logic [7:0]  function_code;
    logic [15:0] register_addr;
    logic [15:0] request_value;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_word_t;

  typedef struct packed {
    logic        report_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        reply_ok;
    logic        crc_good;
    logic        addr_match;
    logic        too_short;
    logic [15:0] reply_value;
  } out_word_t;

  // Check results of a reply, handed from the receive checker to the top.
  typedef struct packed {
    logic        crc_good;
    logic        addr_match;
    logic        too_short;
    logic [15:0] reply_value;
  } rx_report_t;

  // One byte through the reflected CRC, one bit per step.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/mbrc_rx_check.sv
// ----------------------------------------------------------------------------
// Modbus RTU reply checker
// Running CRC, saturating byte count and kept reply bytes for one reply.
// ----------------------------------------------------------------------------
module mbrc_rx_check
  import mbrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [7:0]  expected_addr_i,
  output rx_report_t  report_o
);

  localparam logic [7:0] POS_FIRST  = 8'd0;
  localparam logic [7:0] POS_THIRD  = 8'd3;
  localparam logic [7:0] POS_FOURTH = 8'd4;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  third_q, third_d;
  logic [7:0]  fourth_q, fourth_d;

  // State after this byte; the report is taken from it.
  always_comb begin
    crc_d    = crc16_byte(crc_q, rx_byte_i);
    first_d  = (count_q == POS_FIRST)  ? rx_byte_i : first_q;
    third_d  = (count_q == POS_THIRD)  ? rx_byte_i : third_q;
    fourth_d = (count_q == POS_FOURTH) ? rx_byte_i : fourth_q;
    count_d  = (count_q != COUNT_MAX) ? count_q + 8'd1 : count_q;

    report_o.crc_good    = (crc_d == 16'h0000);
    report_o.addr_match  = (first_d == expected_addr_i);
    report_o.too_short   = (count_d < MIN_REPLY);
    report_o.reply_value = {third_d, fourth_d};
  end

  // The last byte closes the reply and the state starts over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      count_q  <= '0;
      first_q  <= '0;
      third_q  <= '0;
      fourth_q <= '0;
    end else if (take_i) begin
      if (rx_last_i) begin
        crc_q    <= CRC_INIT;
        count_q  <= '0;
        first_q  <= '0;
        third_q  <= '0;
        fourth_q <= '0;
      end else begin
        crc_q    <= crc_d;
        count_q  <= count_d;
        first_q  <= first_d;
        third_q  <= third_d;
        fourth_q <= fourth_d;
      end
    end
  end

endmodule

// File: rtl/modbus_rtu_request_and_reply_check.sv
// ----------------------------------------------------------------------------
// Modbus RTU request and reply check
// Serializes a master request frame with its CRC and checks the reply bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Word
//   --------  ---------  -----------------------  ----------------------------
//   in        input      in_valid_i / in_stall_o  in_word_t  (request or byte)
//   out       output     out_valid_o/out_stall_i  out_word_t (tx byte/report)
//
// Received bytes can arrive back to back. A request holds the input register
// until all eight frame bytes are out, one frame byte per cycle unless the
// output stalls; the transmit CRC advances one byte per cycle over the frame.
// The output register lets a new word be accepted while a result still waits.
// Reset clears all control state at once; there is no clearing pass.
// A stall on the output holds any word that needs to emit a result.
//
module modbus_rtu_request_and_reply_check
  import mbrc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam logic [2:0] TX_LAST_IDX = 3'(FRAME_LEN - 1);
  localparam logic [2:0] TX_CRC_IDX  = 3'(FRAME_LEN - 2);

  // Input register holding the word under work.
  logic      in_valid_q;
  in_word_t  in_word_q;

  // Output register.
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;

  // Request serializer: byte position and running CRC of the frame.
  logic [2:0]  tx_idx_q;
  logic [15:0] tx_crc_q;
  logic [15:0] tx_crc_run;
  logic [7:0]  tx_byte_sel;

  // Address the next reply must carry.
  logic [7:0] exp_addr_q;

  logic       req_pending, rx_pending, out_free;
  logic       tx_emit, rx_take, consume, in_accept, out_load;
  rx_report_t rx_report;

  // The receive checker keeps the running state of the reply.
  mbrc_rx_check u_rx_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (rx_take),
    .rx_byte_i       (in_word_q.rx_byte),
    .rx_last_i       (in_word_q.rx_last),
    .expected_addr_i (exp_addr_q),
    .report_o        (rx_report)
  );

  always_comb begin
    req_pending = in_valid_q && (in_word_q.opcode == OP_REQUEST);
    rx_pending  = in_valid_q && (in_word_q.opcode == OP_RX_BYTE);
    out_free    = !out_valid_q || !out_stall_i;

    // A request emits one frame byte each cycle the output can take it.
    tx_emit = req_pending && out_free;
    // A byte that closes no reply needs no output slot.
    rx_take = rx_pending && (!in_word_q.rx_last || out_free);

    consume    = (tx_emit && (tx_idx_q == TX_LAST_IDX)) || rx_take;
    in_stall_o = in_valid_q && !consume;
    in_accept  = in_valid_i && !in_stall_o;
    out_load   = tx_emit || (rx_take && in_word_q.rx_last);
  end

  // Frame byte for the current position; the CRC starts fresh on byte zero.
  always_comb begin
    tx_crc_run = (tx_idx_q == 3'd0) ? CRC_INIT : tx_crc_q;
    case (tx_idx_q)
      3'd0:    tx_byte_sel = in_word_q.device_addr;
      3'd1:    tx_byte_sel = in_word_q.function_code;
      3'd2:    tx_byte_sel = in_word_q.register_addr[15:8];
      3'd3:    tx_byte_sel = in_word_q.register_addr[7:0];
      3'd4:    tx_byte_sel = in_word_q.request_value[15:8];
      3'd5:    tx_byte_sel = in_word_q.request_value[7:0];
      3'd6:    tx_byte_sel = tx_crc_q[7:0];
      3'd7:    tx_byte_sel = tx_crc_q[15:8];
      default: tx_byte_sel = '0;
    endcase
  end

  always_comb begin
    out_word_d = '0;
    if (req_pending) begin
      out_word_d.report_kind = KIND_TX_BYTE;
      out_word_d.tx_byte     = tx_byte_sel;
      out_word_d.last        = (tx_idx_q == TX_LAST_IDX);
    end else begin
      out_word_d.report_kind = KIND_REPORT;
      out_word_d.last        = 1'b1;
      out_word_d.crc_good    = rx_report.crc_good;
      out_word_d.addr_match  = rx_report.addr_match;
      out_word_d.too_short   = rx_report.too_short;
      out_word_d.reply_ok    = rx_report.crc_good && rx_report.addr_match &&
                               !rx_report.too_short;
      out_word_d.reply_value = rx_report.reply_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tx_idx_q    <= '0;
      exp_addr_q  <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (tx_emit) begin
        tx_idx_q <= tx_idx_q + 3'd1;
      end
      // The request address becomes the expected reply address.
      if (tx_emit && (tx_idx_q == 3'd0)) begin
        exp_addr_q <= in_word_q.device_addr;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
    if (out_load) begin
      out_word_q <= out_word_d;
    end
    if (tx_emit && (tx_idx_q < TX_CRC_IDX)) begin
      tx_crc_q <= crc16_byte(tx_crc_run, tx_byte_sel);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // The serializer is only ever mid-frame while a request sits in the input.
  a_tx_idx_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_idx_q != 3'd0) |-> (in_valid_q && (in_word_q.opcode == OP_REQUEST)))
    else $error("serializer mid-frame without a pending request");

  // A report is always marked last and its overall verdict agrees with its parts.
  a_report_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_word_q.report_kind == KIND_REPORT)) |->
      (out_word_q.last && (out_word_q.reply_ok ==
        (out_word_q.crc_good && out_word_q.addr_match && !out_word_q.too_short))))
    else $error("inconsistent reply report");

  // A transmit byte marked last is the eighth byte of its frame.
  a_tx_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_emit && out_word_d.last) |-> (tx_idx_q == TX_LAST_IDX))
    else $error("frame end marked at the wrong byte");
`endif

endmodule
